[rtl/isar_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// isar_pkg
// Shared types and codes for the input source activity router.
// ----------------------------------------------------------------------------
package isar_pkg;

  localparam int unsigned SUM_W   = 17;
  localparam int unsigned DELAY_W = 16;
  localparam int unsigned SEQ_W   = 32;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned DELTA_W = 16;
  localparam int unsigned CFG_W   = 17;

  localparam logic [SUM_W-1:0]   DIST_RESET  = SUM_W'(10);
  localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(120);
  localparam logic [SUM_W-1:0]   SUM_MAX     = {SUM_W{1'b1}};

  localparam logic CMD_ACTIVITY  = 1'b0;
  localparam logic CMD_FRAME_END = 1'b1;

  localparam logic [1:0] SRC_KEYBOARD = 2'd0;
  localparam logic [1:0] SRC_MOUSE    = 2'd1;
  localparam logic [1:0] SRC_GAMEPAD  = 2'd2;

  localparam logic [3:0] KIND_MOUSE_DELTA   = 4'd0;
  localparam logic [3:0] KIND_MOUSE_BUTTON  = 4'd1;
  localparam logic [3:0] KIND_WHEEL         = 4'd2;
  localparam logic [3:0] KIND_KEY_PRESS     = 4'd3;
  localparam logic [3:0] KIND_KEY_CHAR      = 4'd4;
  localparam logic [3:0] KIND_PAD_BUTTON    = 4'd5;
  localparam logic [3:0] KIND_ANALOG_ENTER  = 4'd6;
  localparam logic [3:0] KIND_ANALOG_CHANGE = 4'd7;
  localparam logic [3:0] KIND_TOUCH_PRESS   = 4'd8;

  localparam logic [1:0] DOM_GAMEPLAY  = 2'd0;
  localparam logic [1:0] DOM_MENU_PTR  = 2'd1;
  localparam logic [1:0] DOM_MENU_NAV  = 2'd2;

  localparam logic CFG_PROMOTE_DISTANCE = 1'b0;
  localparam logic CFG_PROMOTE_DELAY    = 1'b1;

  typedef struct packed {
    logic                      cmd;
    logic [1:0]                source;
    logic [3:0]                kind;
    logic [SEQ_W-1:0]          seq;
    logic signed [DELTA_W-1:0] delta_x;
    logic signed [DELTA_W-1:0] delta_y;
    logic                      menu_mode;
    logic [TIME_W-1:0]         now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                domain;
    logic                      strong_for_menu_owner;
    logic                      qualifies_cursor;
    logic                      by_owner_timer;
    logic [1:0]                out_source;
    logic [3:0]                out_kind;
    logic [SEQ_W-1:0]          out_seq;
    logic signed [DELTA_W-1:0] out_dx;
    logic signed [DELTA_W-1:0] out_dy;
  } out_item_t;

  typedef struct packed {
    logic               pending_valid;
    logic [SEQ_W-1:0]   pending_seq;
    logic [DELTA_W-1:0] pending_dx;
    logic [DELTA_W-1:0] pending_dy;
    logic [SUM_W-1:0]   motion_sum;
    logic [TIME_W-1:0]  window_start;
    logic               promoted_flag;
  } ptr_regs_t;

  typedef struct packed {
    logic [SUM_W-1:0]   promote_distance;
    logic [DELAY_W-1:0] promote_delay_ms;
  } cfg_regs_t;

  function automatic logic [SUM_W-1:0] mag16(input logic [DELTA_W-1:0] v);
    logic [SUM_W-1:0] ext;
    ext = {1'b0, v};
    if (v[DELTA_W-1]) begin
      return SUM_W'(17'h10000) - ext;
    end
    return ext;
  endfunction

endpackage
`default_nettype wire

[rtl/input_source_activity_router_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// input_source_activity_router_unit
// Routes strong input events at once and promotes accumulated mouse motion.
// ----------------------------------------------------------------------------
// Accepts one transaction per clock cycle while the output side keeps taking
// results. Each transaction is captured in an input register, processed by
// the core (which updates the pointer state, frame snapshot and strongest
// sequence number), and any result is captured in an output register. Write
// the promotion registers only while the block is idle.
module input_source_activity_router_unit import isar_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  cfg_regs_t cfg_r;
  logic      s1_valid;
  in_item_t  s1_data;
  logic      advance;
  logic      emit;
  out_item_t result;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.promote_distance <= DIST_RESET;
      cfg_r.promote_delay_ms <= DELAY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PROMOTE_DISTANCE: cfg_r.promote_distance <= cfg_wdata[SUM_W-1:0];
        CFG_PROMOTE_DELAY:    cfg_r.promote_delay_ms <= cfg_wdata[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance = s1_valid && (!out_valid_r || out_ready);

  isar_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_data  (s1_data)
  );

  isar_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .item   (s1_data),
    .cfg    (cfg_r),
    .emit   (emit),
    .result (result)
  );

  assign out_valid_nxt = (advance && emit) || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

[rtl/isar_in_stage.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// isar_in_stage
// Input register: holds one accepted transaction until the core consumes it.
// ----------------------------------------------------------------------------
module isar_in_stage import isar_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  input  wire logic     advance,
  output logic          s1_valid,
  output in_item_t      s1_data
);

  logic     valid_r, valid_nxt;
  in_item_t data_r;

  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_valid || (valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

  assign s1_valid = valid_r;
  assign s1_data  = data_r;

endmodule
`default_nettype wire

[rtl/isar_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// isar_core
// Classification, motion accumulation, frame snapshot and promotion logic.
// ----------------------------------------------------------------------------
module isar_core import isar_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      fire,
  input  wire in_item_t  item,
  input  wire cfg_regs_t cfg,
  output logic           emit,
  output out_item_t      result
);

  ptr_regs_t        cur_r, cur_nxt;
  ptr_regs_t        snap_r, snap_nxt;
  logic [SEQ_W-1:0] lss_r, lss_nxt;

  logic             is_motion;
  logic             is_strong;
  logic             is_mouse, is_pad;
  logic [SUM_W-1:0] base_sum;
  logic [SUM_W:0]   raw_sum;
  logic             restart;
  ptr_regs_t        eof_cur;
  logic [TIME_W:0]  deadline;
  logic             promote;

  always_comb begin
    is_mouse  = item.source == SRC_MOUSE;
    is_pad    = item.source == SRC_GAMEPAD;
    is_motion = is_mouse && item.kind == KIND_MOUSE_DELTA;
    case (item.source)
      SRC_KEYBOARD: is_strong = item.kind == KIND_KEY_PRESS || item.kind == KIND_KEY_CHAR;
      SRC_MOUSE:    is_strong = item.kind == KIND_MOUSE_BUTTON || item.kind == KIND_WHEEL;
      SRC_GAMEPAD:  is_strong = item.kind == KIND_PAD_BUTTON || item.kind == KIND_ANALOG_ENTER
                             || item.kind == KIND_ANALOG_CHANGE
                             || item.kind == KIND_TOUCH_PRESS;
      default:      is_strong = 1'b0;
    endcase
  end

  always_comb begin
    restart  = !cur_r.pending_valid || cur_r.window_start == '0;
    base_sum = restart ? '0 : cur_r.motion_sum;
    raw_sum  = {1'b0, base_sum} + {1'b0, mag16(item.delta_x)} + {1'b0, mag16(item.delta_y)};
  end

  always_comb begin
    eof_cur = cur_r;
    if (cur_r.pending_valid && lss_r > cur_r.pending_seq) begin
      eof_cur = '0;
    end
    deadline = {1'b0, eof_cur.window_start} + (TIME_W+1)'(cfg.promote_delay_ms);
    promote  = eof_cur.pending_valid && !eof_cur.promoted_flag
            && eof_cur.motion_sum >= cfg.promote_distance
            && {1'b0, item.now_ms} >= deadline
            && eof_cur.pending_seq > lss_r;
  end

  always_comb begin
    cur_nxt  = cur_r;
    snap_nxt = snap_r;
    lss_nxt  = lss_r;
    emit     = 1'b0;
    result   = '0;
    if (item.cmd == CMD_ACTIVITY) begin
      if (is_motion) begin
        if (item.seq > lss_r) begin
          cur_nxt.motion_sum    = raw_sum[SUM_W] ? SUM_MAX : raw_sum[SUM_W-1:0];
          cur_nxt.window_start  = restart ? item.now_ms : cur_r.window_start;
          cur_nxt.promoted_flag = restart ? 1'b0 : cur_r.promoted_flag;
          cur_nxt.pending_valid = 1'b1;
          cur_nxt.pending_seq   = item.seq;
          cur_nxt.pending_dx    = item.delta_x;
          cur_nxt.pending_dy    = item.delta_y;
        end
      end else if (is_strong) begin
        cur_nxt = snap_r;
        if (item.seq > lss_r) begin
          lss_nxt = item.seq;
        end
        emit = 1'b1;
        result.domain = item.menu_mode ? (is_mouse ? DOM_MENU_PTR : DOM_MENU_NAV)
                                       : DOM_GAMEPLAY;
        result.strong_for_menu_owner = item.menu_mode;
        result.qualifies_cursor      = item.menu_mode && (is_mouse || is_pad);
        result.by_owner_timer        = 1'b0;
        result.out_source            = item.source;
        result.out_kind              = item.kind;
        result.out_seq               = item.seq;
        result.out_dx                = item.delta_x;
        result.out_dy                = item.delta_y;
      end
    end else begin
      cur_nxt = eof_cur;
      if (promote) begin
        emit = 1'b1;
        result.domain                = item.menu_mode ? DOM_MENU_PTR : DOM_GAMEPLAY;
        result.strong_for_menu_owner = 1'b0;
        result.qualifies_cursor      = item.menu_mode;
        result.by_owner_timer        = 1'b1;
        result.out_source            = SRC_MOUSE;
        result.out_kind              = KIND_MOUSE_DELTA;
        result.out_seq               = eof_cur.pending_seq;
        result.out_dx                = eof_cur.pending_dx;
        result.out_dy                = eof_cur.pending_dy;
        cur_nxt                      = '0;
        cur_nxt.promoted_flag        = 1'b1;
      end
      snap_nxt = cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r  <= '0;
      snap_r <= '0;
      lss_r  <= '0;
    end else if (fire) begin
      cur_r  <= cur_nxt;
      snap_r <= snap_nxt;
      lss_r  <= lss_nxt;
    end
  end

endmodule
`default_nettype wire
